// ===== hdl/frps_pkg.sv =====
// Shared types and constants of the fixed-radius point search block.
package frps_pkg;

    localparam int TABLE_DEPTH = 512;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int SLOT_W   = 9;
    localparam int LAT_W    = 20;
    localparam int LON_W    = 21;
    localparam int COUNT_W  = 10;
    localparam int RADIUS_W = 42;
    localparam int ENTRY_W  = LAT_W + LON_W;
    localparam int SQLAT_W  = 2 * LAT_W + 1;
    localparam int DIST_W   = 2 * LON_W + 1;
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 16;

    // 1.5 square degrees in square arc-seconds.
    localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(3 * 3600 * 3600 / 2);

    typedef logic [ADDR_W-1:0]   addr_t;
    typedef logic [CNT_W-1:0]    cnt_t;
    typedef logic [SLOT_W-1:0]   slot_t;
    typedef logic [COUNT_W-1:0]  count_t;
    typedef logic [RADIUS_W-1:0] radius_t;
    typedef logic [ENTRY_W-1:0]  entry_t;
    typedef logic [DIST_W-1:0]   dist_t;
    typedef logic signed [LAT_W-1:0] lat_t;
    typedef logic signed [LON_W-1:0] lon_t;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef logic cfg_idx_t;
    localparam cfg_idx_t REG_ENTRY_COUNT = 1'b0;
    localparam cfg_idx_t REG_RADIUS      = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    // Result of one distance check, in table order.
    typedef struct packed {
        logic  valid;
        logic  match;
        addr_t idx;
    } dist_res_t;

endpackage

// ===== hdl/frps_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module frps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/frps_dist.sv =====
// Three-stage squared-distance and threshold check for one table entry per cycle.
module frps_dist (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  frps_pkg::addr_t     in_idx,
    input  frps_pkg::entry_t    entry,
    input  frps_pkg::lat_t      qlat,
    input  frps_pkg::lon_t      qlon,
    input  frps_pkg::radius_t   radius,
    output frps_pkg::dist_res_t res
);

    logic                                  s1_valid_reg, s2_valid_reg, s3_valid_reg;
    frps_pkg::addr_t                       s1_idx_reg, s2_idx_reg, s3_idx_reg;
    logic signed [frps_pkg::LAT_W:0]       dlat_reg;
    logic signed [frps_pkg::LON_W:0]       dlon_reg;
    logic [frps_pkg::SQLAT_W-1:0]          sqlat_reg;
    logic [frps_pkg::DIST_W-1:0]           sqlon_reg;
    logic                                  match_reg;

    frps_pkg::lat_t                        t_lat;
    frps_pkg::lon_t                        t_lon;
    logic signed [frps_pkg::LAT_W:0]       dlat_next;
    logic signed [frps_pkg::LON_W:0]       dlon_next;
    logic signed [2*frps_pkg::LAT_W+1:0]   plat;
    logic signed [2*frps_pkg::LON_W+1:0]   plon;
    frps_pkg::dist_t                       dist_sum;
    logic                                  match_next;

    always_comb
    begin
        // Entries are stored as longitude above latitude.
        t_lat     = frps_pkg::lat_t'(entry[frps_pkg::LAT_W-1:0]);
        t_lon     = frps_pkg::lon_t'(entry[frps_pkg::ENTRY_W-1:frps_pkg::LAT_W]);
        dlat_next = {t_lat[frps_pkg::LAT_W-1], t_lat} - {qlat[frps_pkg::LAT_W-1], qlat};
        dlon_next = {t_lon[frps_pkg::LON_W-1], t_lon} - {qlon[frps_pkg::LON_W-1], qlon};
        plat      = dlat_reg * dlat_reg;
        plon      = dlon_reg * dlon_reg;
        dist_sum  = sqlon_reg + frps_pkg::dist_t'(sqlat_reg);
        match_next = dist_sum < frps_pkg::dist_t'(radius);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_idx_reg <= in_idx;
        dlat_reg   <= dlat_next;
        dlon_reg   <= dlon_next;
        s2_idx_reg <= s1_idx_reg;
        sqlat_reg  <= plat[frps_pkg::SQLAT_W-1:0];
        sqlon_reg  <= plon[frps_pkg::DIST_W-1:0];
        s3_idx_reg <= s2_idx_reg;
        match_reg  <= match_next;
    end

    assign res.valid = s3_valid_reg;
    assign res.match = match_reg;
    assign res.idx   = s3_idx_reg;

endmodule

// ===== hdl/fixed_radius_point_search.sv =====
// Top level of the fixed-radius point search: sequencer, table memory and distance unit.
//
// Usage:
//   s_axis carries commands. tuser is the command (write or query); tdata holds
//   slot, latitude and longitude. A write item stores one point in the table
//   and gives no result. A query item scans slots 0 to entry_count-1 (at most
//   511) in order and gives one result item on m_axis: tuser is the found flag
//   and tdata the lowest matching slot (0 when nothing matched).
//   The cfg channel writes entry_count (index 0) and radius_squared (index 1);
//   it is always ready; the user must write it only while the block is idle (not enforced).
// Timing:
//   A query ends at its first matching slot or after a full scan of N slots.
//   The table memory feeds one entry per cycle into a four-deep read and
//   distance pipeline, so the scan length sets the rate.
//   One item is worked on at a time; s_axis_tready is high only while idle.
//   A finished result waits in the output register while further writes are
//   accepted; a query result waits until the previous one has been taken.
// Reset:
//   entry_count clears to 0 and radius_squared returns to 1.5 square degrees.
//   The table is not cleared; a slot must be written before a query scans it.
module fixed_radius_point_search (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // slot [8:0], lat_arcsec [28:9], lon_arcsec [49:29], zero [55:50]
    input  logic [frps_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // cmd [0]
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // match_slot [8:0], zero [15:9]
    output logic [frps_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // found [0]
    output logic                              m_axis_tuser,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  frps_pkg::cfg_idx_t                cfg_index,
    input  logic [frps_pkg::RADIUS_W-1:0]     cfg_data
);

    frps_pkg::state_t   state_reg, state_next;
    frps_pkg::cnt_t     issue_reg, issue_next;
    frps_pkg::cnt_t     limit_reg, limit_next;
    logic [2:0]         inflight_reg, inflight_next;
    logic               stop_reg, stop_next;
    logic               found_reg, found_next;
    frps_pkg::addr_t    idx_reg, idx_next;
    frps_pkg::lat_t     qlat_reg, qlat_next;
    frps_pkg::lon_t     qlon_reg, qlon_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_found_reg, out_found_next;
    frps_pkg::slot_t    out_slot_reg, out_slot_next;
    frps_pkg::count_t   entry_count_reg, entry_count_next;
    frps_pkg::radius_t  radius_reg, radius_next;
    logic               rd_valid_reg;
    frps_pkg::addr_t    rd_idx_reg;

    logic               in_fire;
    logic               issue;
    logic               wr_en;
    frps_pkg::slot_t    in_slot;
    frps_pkg::lat_t     in_lat;
    frps_pkg::lon_t     in_lon;
    frps_pkg::entry_t   rd_data;
    frps_pkg::dist_res_t res;

    assign in_slot = s_axis_tdata[frps_pkg::SLOT_W-1:0];
    assign in_lat  = s_axis_tdata[frps_pkg::SLOT_W+frps_pkg::LAT_W-1:frps_pkg::SLOT_W];
    assign in_lon  = s_axis_tdata[frps_pkg::SLOT_W+frps_pkg::ENTRY_W-1:
                                  frps_pkg::SLOT_W+frps_pkg::LAT_W];

    assign s_axis_tready = (state_reg == frps_pkg::ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign wr_en         = in_fire && (s_axis_tuser == frps_pkg::CMD_WRITE)
                           && (32'(in_slot) < frps_pkg::TABLE_DEPTH);
    assign issue         = (state_reg == frps_pkg::ST_SCAN) && !stop_reg
                           && (issue_reg < limit_reg);
    assign cfg_ready     = 1'b1;

    frps_ram #(
        .WIDTH (frps_pkg::ENTRY_W),
        .DEPTH (frps_pkg::TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (wr_en),
        .waddr (frps_pkg::addr_t'(in_slot)),
        .wdata ({in_lon, in_lat}),
        .raddr (issue_reg[frps_pkg::ADDR_W-1:0]),
        .rdata (rd_data)
    );

    frps_dist u_dist (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (rd_valid_reg),
        .in_idx   (rd_idx_reg),
        .entry    (rd_data),
        .qlat     (qlat_reg),
        .qlon     (qlon_reg),
        .radius   (radius_reg),
        .res      (res)
    );

    always_comb
    begin
        state_next       = state_reg;
        issue_next       = issue_reg;
        limit_next       = limit_reg;
        stop_next        = stop_reg;
        found_next       = found_reg;
        idx_next         = idx_reg;
        qlat_next        = qlat_reg;
        qlon_next        = qlon_reg;
        out_valid_next   = out_valid_reg;
        out_found_next   = out_found_reg;
        out_slot_next    = out_slot_reg;
        entry_count_next = entry_count_reg;
        radius_next      = radius_reg;
        inflight_next    = inflight_reg + {2'b00, issue} - {2'b00, res.valid};

        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                frps_pkg::REG_ENTRY_COUNT: entry_count_next = cfg_data[frps_pkg::COUNT_W-1:0];
                frps_pkg::REG_RADIUS:      radius_next      = cfg_data;
                default:                   radius_next      = radius_reg;
            endcase
        end

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (issue)
        begin
            issue_next = issue_reg + 1'b1;
        end

        // Results come back in slot order, so the first match is the lowest slot.
        if (res.valid && res.match && !stop_reg)
        begin
            stop_next  = 1'b1;
            found_next = 1'b1;
            idx_next   = res.idx;
        end

        unique case (state_reg)
            frps_pkg::ST_IDLE:
            begin
                if (in_fire && (s_axis_tuser == frps_pkg::CMD_QUERY))
                begin
                    state_next = frps_pkg::ST_SCAN;
                    issue_next = '0;
                    stop_next  = 1'b0;
                    found_next = 1'b0;
                    idx_next   = '0;
                    qlat_next  = in_lat;
                    qlon_next  = in_lon;
                    if (32'(entry_count_reg) > frps_pkg::TABLE_DEPTH)
                    begin
                        limit_next = frps_pkg::cnt_t'(frps_pkg::TABLE_DEPTH);
                    end
                    else
                    begin
                        limit_next = frps_pkg::cnt_t'(entry_count_reg);
                    end
                end
            end
            frps_pkg::ST_SCAN:
            begin
                // Wait for the pipeline to drain so no late result leaks into the next query.
                if ((inflight_reg == 3'd0) && (stop_reg || (issue_reg == limit_reg)))
                begin
                    state_next = frps_pkg::ST_DONE;
                end
            end
            frps_pkg::ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_found_next = found_reg;
                    out_slot_next  = frps_pkg::slot_t'(idx_reg);
                    state_next     = frps_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = frps_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= frps_pkg::ST_IDLE;
            issue_reg       <= '0;
            limit_reg       <= '0;
            inflight_reg    <= '0;
            stop_reg        <= 1'b0;
            found_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
            entry_count_reg <= '0;
            radius_reg      <= frps_pkg::RADIUS_RESET;
            rd_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            issue_reg       <= issue_next;
            limit_reg       <= limit_next;
            inflight_reg    <= inflight_next;
            stop_reg        <= stop_next;
            found_reg       <= found_next;
            out_valid_reg   <= out_valid_next;
            entry_count_reg <= entry_count_next;
            radius_reg      <= radius_next;
            rd_valid_reg    <= issue;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        qlat_reg      <= qlat_next;
        qlon_reg      <= qlon_next;
        out_found_reg <= out_found_next;
        out_slot_reg  <= out_slot_next;
        rd_idx_reg    <= issue_reg[frps_pkg::ADDR_W-1:0];
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_found_reg;
    assign m_axis_tdata  = {{(frps_pkg::OUT_DATA_W - frps_pkg::SLOT_W){1'b0}}, out_slot_reg};

`ifndef SYNTHESIS
    a_res_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (state_reg == frps_pkg::ST_SCAN))
        else $error("distance result outside a scan");

    a_inflight_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (inflight_reg <= 3'd4))
        else $error("more entries in flight than pipeline stages");

    a_issue_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        issue |-> (issue_reg < frps_pkg::cnt_t'(frps_pkg::TABLE_DEPTH)))
        else $error("read issued beyond the table");

    a_result_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg == frps_pkg::ST_DONE))
        else $error("result shown without a finished scan");
`endif

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the fixed-radius point search block.
import frps_pkg::*;

typedef struct {
    logic  found;
    slot_t slot;
} search_hit_t;

// Keeps its own copy of the point table and registers and predicts each query result.
class search_scoreboard;
    lat_t        lat_mem[TABLE_DEPTH];
    lon_t        lon_mem[TABLE_DEPTH];
    count_t      entry_count;
    radius_t     radius_sq;
    search_hit_t expected_hits[$];
    int          mismatches;

    function new();
        entry_count = '0;
        radius_sq   = RADIUS_RESET;
        mismatches  = 0;
    endfunction

    function void note_config(cfg_idx_t idx, radius_t word);
        if (idx == REG_ENTRY_COUNT)
            entry_count = word[COUNT_W-1:0];
        else
            radius_sq = word;
    endfunction

    function search_hit_t first_within_radius(lat_t lat, lon_t lon);
        search_hit_t hit;
        int          limit;
        longint      dlat;
        longint      dlon;
        hit.found = 1'b0;
        hit.slot  = '0;
        limit = (int'(entry_count) > TABLE_DEPTH) ? TABLE_DEPTH : int'(entry_count);
        for (int i = 0; i < limit; i++)
        begin
            dlat = longint'(lat_mem[i]) - longint'(lat);
            dlon = longint'(lon_mem[i]) - longint'(lon);
            // The squared distance stays below 2^43, so signed 64-bit math is exact.
            if (dlat * dlat + dlon * dlon < longint'(radius_sq))
            begin
                hit.found = 1'b1;
                hit.slot  = slot_t'(i);
                break;
            end
        end
        return hit;
    endfunction

    function void note_command(logic cmd, slot_t slot, lat_t lat, lon_t lon);
        if (cmd == CMD_WRITE)
        begin
            lat_mem[slot] = lat;
            lon_mem[slot] = lon;
        end
        else
            expected_hits.push_back(first_within_radius(lat, lon));
    endfunction

    function void check_result(logic found, logic [OUT_DATA_W-1:0] word);
        search_hit_t want;
        if (expected_hits.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result item: found %0d slot %0d",
                         found, word[SLOT_W-1:0]);
            return;
        end
        want = expected_hits.pop_front();
        if (found !== want.found || word[SLOT_W-1:0] !== want.slot
            || word[OUT_DATA_W-1:SLOT_W] !== '0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("result mismatch: found exp %0d got %0d, slot exp %0d got %0d, pad %h",
                         want.found, found, want.slot, word[SLOT_W-1:0],
                         word[OUT_DATA_W-1:SLOT_W]);
        end
    endfunction

    function int pending();
        return expected_hits.size();
    endfunction
endclass

module tb_top;

    localparam int   GAP_MAX      = 15;
    localparam int   STALL_LIMIT  = 4000;
    localparam int   DRAIN_CYCLES = 16;
    localparam int   TAIL_CYCLES  = 40;
    localparam int   PHASES       = 10;
    localparam int   PHASE_ITEMS  = 65;
    localparam int   LAT_SPAN     = 324000;
    localparam int   LON_SPAN     = 648000;
    localparam lat_t LAT_LO       = lat_t'(1 << (LAT_W - 1));
    localparam lat_t LAT_HI       = lat_t'((1 << (LAT_W - 1)) - 1);
    localparam lon_t LON_LO       = lon_t'(1 << (LON_W - 1));
    localparam lon_t LON_HI       = lon_t'((1 << (LON_W - 1)) - 1);

    typedef struct {
        lat_t lat;
        lon_t lon;
    } point_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    cfg_idx_t              cfg_index = REG_ENTRY_COUNT;
    radius_t               cfg_data = '0;

    search_scoreboard sb;
    bit               written[TABLE_DEPTH];
    bit               send_back_to_back = 1'b0;
    bit               recv_no_stall = 1'b0;
    int               idle_cycles = 0;

    fixed_radius_point_search uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Observes all three channels; result checks run before new queries are noted.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tuser, m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready)
                sb.note_command(s_axis_tuser, s_axis_tdata[SLOT_W-1:0],
                                lat_t'(s_axis_tdata[SLOT_W +: LAT_W]),
                                lon_t'(s_axis_tdata[SLOT_W + LAT_W +: LON_W]));
            if (cfg_valid && cfg_ready)
                sb.note_config(cfg_index, cfg_data);
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)
                || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else if (idle_cycles >= STALL_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
            else
                idle_cycles = idle_cycles + 1;
        end
    end

    // Result side: random stall before each item, with stretches of no stalls.
    initial
    begin
        int stall;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = recv_no_stall ? 0 : $urandom_range(0, GAP_MAX);
            if ($urandom_range(0, 39) == 0)
                recv_no_stall = !recv_no_stall;
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
        end
    end

    task automatic send_item(logic cmd, slot_t slot, lat_t lat, lon_t lon);
        int gap;
        gap = send_back_to_back ? 0 : $urandom_range(0, GAP_MAX);
        if ($urandom_range(0, 39) == 0)
            send_back_to_back = !send_back_to_back;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= IN_DATA_W'({lon, lat, slot});
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic store_point(slot_t slot, lat_t lat, lon_t lon);
        written[slot] = 1'b1;
        send_item(CMD_WRITE, slot, lat, lon);
    endtask

    task automatic send_query(lat_t lat, lon_t lon);
        send_item(CMD_QUERY, slot_t'($urandom), lat, lon);
    endtask

    // Stops the command stream and waits until every query result has come back.
    task automatic settle(int extra);
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic set_regs(radius_t count_word, radius_t radius_word);
        cfg_valid <= 1'b1;
        cfg_index <= REG_ENTRY_COUNT;
        cfg_data  <= count_word;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_index <= REG_RADIUS;
        cfg_data  <= radius_word;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic int table_prefix();
        int n;
        n = 0;
        while (n < TABLE_DEPTH && written[n])
            n++;
        return n;
    endfunction

    function automatic point_t random_point();
        point_t p;
        case ($urandom_range(0, 9))
            0:
            begin
                p.lat = lat_t'($urandom);
                p.lon = lon_t'($urandom);
            end
            1:
            begin
                case ($urandom_range(0, 3))
                    0:       p.lat = LAT_LO;
                    1:       p.lat = LAT_HI;
                    2:       p.lat = lat_t'(LAT_SPAN);
                    default: p.lat = lat_t'(-LAT_SPAN);
                endcase
                case ($urandom_range(0, 3))
                    0:       p.lon = LON_LO;
                    1:       p.lon = LON_HI;
                    2:       p.lon = lon_t'(LON_SPAN);
                    default: p.lon = lon_t'(-LON_SPAN);
                endcase
            end
            2, 3:
            begin
                // A dense cluster, so that several slots can match one query.
                p.lat = lat_t'(int'($urandom_range(0, 6000)) - 3000);
                p.lon = lon_t'(int'($urandom_range(0, 6000)) - 3000);
            end
            default:
            begin
                p.lat = lat_t'(int'($urandom_range(0, 2 * LAT_SPAN)) - LAT_SPAN);
                p.lon = lon_t'(int'($urandom_range(0, 2 * LON_SPAN)) - LON_SPAN);
            end
        endcase
        return p;
    endfunction

    task automatic random_item(int eff);
        point_t p;
        int     k;
        int     spread;
        p = random_point();
        if ($urandom_range(0, 9) < 4)
        begin
            if (eff > 0 && $urandom_range(0, 1) == 0)
                store_point(slot_t'($urandom_range(0, eff - 1)), p.lat, p.lon);
            else
                store_point(slot_t'($urandom_range(0, TABLE_DEPTH - 1)), p.lat, p.lon);
        end
        else if (eff > 0 && $urandom_range(0, 1) == 0)
        begin
            // Aim close to a scanned slot so that matches happen at every depth.
            k = $urandom_range(0, eff - 1);
            case ($urandom_range(0, 2))
                0:       spread = 4;
                1:       spread = 2000;
                default: spread = 20000;
            endcase
            send_query(lat_t'(int'(sb.lat_mem[k]) + int'($urandom_range(0, 2 * spread)) - spread),
                       lon_t'(int'(sb.lon_mem[k]) + int'($urandom_range(0, 2 * spread)) - spread));
        end
        else
            send_query(p.lat, p.lon);
    endtask

    initial
    begin
        int      eff;
        radius_t count_word;
        radius_t radius_word;
        point_t  p;

        sb = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset configuration scans nothing, so this query finds no match.
        send_query(lat_t'(0), lon_t'(0));
        store_point(slot_t'(0), lat_t'(0), lon_t'(0));
        store_point(slot_t'(1), lat_t'(LAT_SPAN), lon_t'(LON_SPAN));
        store_point(slot_t'(2), lat_t'(-LAT_SPAN), lon_t'(-LON_SPAN));
        store_point(slot_t'(3), LAT_LO, LON_LO);
        store_point(slot_t'(4), LAT_HI, LON_HI);
        store_point(slot_t'(TABLE_DEPTH - 1), lat_t'(-1), lon_t'(-1));

        // Default radius: 4409 squared lies just inside, 4410 squared just outside.
        settle(DRAIN_CYCLES);
        set_regs(radius_t'(5), RADIUS_RESET);
        send_query(lat_t'(0), lon_t'(4409));
        send_query(lat_t'(0), lon_t'(4410));
        send_query(lat_t'(LAT_SPAN - 100), lon_t'(LON_SPAN));
        send_query(LAT_HI, LON_HI);
        send_query(LAT_LO, LON_LO);
        send_query(lat_t'(-LAT_SPAN), lon_t'(100 - LON_SPAN));

        // A distance equal to the threshold does not match.
        settle(DRAIN_CYCLES);
        set_regs(radius_t'(5), radius_t'(25));
        send_query(lat_t'(3), lon_t'(4));
        send_query(lat_t'(3), lon_t'(3));

        settle(DRAIN_CYCLES);
        set_regs(radius_t'(5), '0);
        send_query(lat_t'(0), lon_t'(0));

        settle(DRAIN_CYCLES);
        set_regs(radius_t'(5), '1);
        send_query(LAT_LO, LON_LO);
        send_query(LAT_HI, LON_HI);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    count_word  = radius_t'(1);
                    radius_word = RADIUS_RESET;
                end
                1, 5, 9:
                begin
                    count_word  = (ph == 5) ? radius_t'(TABLE_DEPTH)
                                : (ph == 1) ? radius_t'(8)
                                : radius_t'($urandom_range(0, TABLE_DEPTH - 1));
                    radius_word = radius_t'($urandom_range(1000000, 1000000000));
                end
                2:
                begin
                    count_word  = radius_t'(40);
                    radius_word = radius_t'($urandom_range(0, 5000));
                end
                3:
                begin
                    count_word  = '0;
                    radius_word = '1;
                end
                4:
                begin
                    // Bits above the count field must be dropped.
                    count_word  = radius_t'({$urandom, 10'd200});
                    radius_word = '0;
                end
                6:
                begin
                    count_word  = radius_t'(1023);
                    radius_word = radius_t'($urandom_range(0, 5000));
                end
                7:
                begin
                    count_word  = radius_t'($urandom_range(0, 1023));
                    radius_word = radius_t'({$urandom, $urandom});
                end
                default:
                begin
                    count_word  = radius_t'({$urandom, 10'd600});
                    radius_word = RADIUS_RESET;
                end
            endcase
            eff = (int'(count_word[COUNT_W-1:0]) > TABLE_DEPTH)
                ? TABLE_DEPTH : int'(count_word[COUNT_W-1:0]);

            // Every slot that a query will scan gets written first.
            while (table_prefix() < eff)
            begin
                p = random_point();
                store_point(slot_t'(table_prefix()), p.lat, p.lon);
            end

            settle(DRAIN_CYCLES);
            set_regs(count_word, radius_word);
            repeat (PHASE_ITEMS) random_item(eff);
        end

        settle(TAIL_CYCLES);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/frps_pkg.sv
hdl/frps_ram.sv
hdl/frps_dist.sv
hdl/fixed_radius_point_search.sv
test/tb_top.sv
